FILE: rtl/cd_audio_sector_playback_macros.svh
// Assertion helpers for the CD audio playback block.
`ifndef CD_AUDIO_SECTOR_PLAYBACK_MACROS_SVH
`define CD_AUDIO_SECTOR_PLAYBACK_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define CDAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked only on edges where a result is presented.
`define CDAP_ASSERT_OUT(label, prop, msg) \
  `CDAP_ASSERT(label, out_valid_o |-> (prop), msg)

`endif

FILE: rtl/cdap_pkg.sv
`default_nettype none

package cdap_pkg;

  // Sector geometry
  localparam int unsigned SAMPLES_PER_SECTOR = 588;
  localparam int unsigned LBA_W              = 20;

  // Command codes
  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_STOP  = 3'd2,
    FUNC_PAUSE = 3'd3,
    FUNC_LOAD  = 3'd4
  } func_e;

  // Input item
  typedef struct packed {
    logic [2:0]       func;
    logic [LBA_W-1:0] start_lba;
    logic [LBA_W-1:0] block_count;
    logic             pause_on;
    logic [31:0]      disc_word;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               fetch_request;
    logic [LBA_W-1:0]   fetch_lba;
    logic [2:0]         fetch_count;
    logic               is_playing;
    logic               is_paused;
    logic               has_ended;
    logic [LBA_W-1:0]   current_lba;
  } out_t;

  // Control result waiting for the cache read data
  typedef struct packed {
    logic             sample_en;
    logic             fetch_request;
    logic [LBA_W-1:0] fetch_lba;
    logic [2:0]       fetch_count;
    logic             is_playing;
    logic             is_paused;
    logic             has_ended;
    logic [LBA_W-1:0] current_lba;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/cdap_cache.sv
`default_nettype none

module cdap_cache #(
  parameter int unsigned DEPTH  = 2352,
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [31:0]       wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [31:0]       rdata_o
);

  logic [31:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cdap_ctrl.sv
`default_nettype none

module cdap_ctrl #(
  parameter int unsigned CACHE_SECTORS = 4,
  parameter int unsigned ADDR_W        = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                fire_i,
  input  wire cdap_pkg::in_t       item_i,
  output cdap_pkg::stage_t         stage_o,
  output logic                     mem_we_o,
  output logic [ADDR_W-1:0]        mem_waddr_o,
  output logic                     mem_re_o,
  output logic [ADDR_W-1:0]        mem_raddr_o
);

  import cdap_pkg::*;

  localparam int unsigned CacheWords = CACHE_SECTORS * SAMPLES_PER_SECTOR;
  localparam int unsigned CntW       = $clog2(CACHE_SECTORS + 1);
  localparam int unsigned PtrW       = $clog2(CacheWords + 1);

  logic             disc_q;
  logic             play_q, play_d;
  logic             pause_q, pause_d;
  logic             end_q, end_d;
  logic [LBA_W-1:0] lba_q, lba_d;
  logic [LBA_W-1:0] blk_q, blk_d;
  logic [PtrW-1:0]  sl_q, sl_d;
  logic [PtrW-1:0]  rp_q, rp_d;
  logic [PtrW-1:0]  wp_q, wp_d;

  logic             active;
  logic             rp_ok;
  logic             wp_ok;
  logic [LBA_W-1:0] cnt;

  // Disc presence register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q <= 1'b0;
    end else if (cfg_we_i) begin
      disc_q <= cfg_wdata_i;
    end
  end

  assign active = disc_q && play_q && !pause_q;
  assign rp_ok  = rp_q < PtrW'(CacheWords);
  assign wp_ok  = wp_q < PtrW'(CacheWords);
  assign cnt    = (blk_q >= LBA_W'(CACHE_SECTORS)) ? LBA_W'(CACHE_SECTORS) : blk_q;

  // Next state and result for one item
  always_comb begin
    play_d   = play_q;
    pause_d  = pause_q;
    end_d    = end_q;
    lba_d    = lba_q;
    blk_d    = blk_q;
    sl_d     = sl_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    stage_o  = '0;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    case (item_i.func)
      FUNC_TICK: begin
        if (!active || (blk_q == '0 && sl_q == '0)) begin
          // out of data while playing: playback ends
          if (active && blk_q == '0) begin
            play_d = 1'b0;
            end_d  = 1'b1;
          end
        end else if (sl_q != '0) begin
          if (rp_ok) begin
            mem_re_o          = 1'b1;
            stage_o.sample_en = 1'b1;
            rp_d              = rp_q + 1'b1;
          end
          sl_d = sl_q - 1'b1;
        end else begin
          // cache empty, blocks left: ask for the next sectors
          stage_o.fetch_request = 1'b1;
          stage_o.fetch_lba     = lba_q;
          stage_o.fetch_count   = cnt[2:0];
          lba_d = lba_q + cnt;
          blk_d = blk_q - cnt;
          sl_d  = PtrW'(cnt[CntW-1:0]) * PtrW'(SAMPLES_PER_SECTOR);
          rp_d  = '0;
          wp_d  = '0;
        end
      end
      FUNC_START: begin
        play_d  = 1'b1;
        pause_d = 1'b0;
        end_d   = 1'b0;
        lba_d   = item_i.start_lba;
        blk_d   = item_i.block_count;
      end
      FUNC_STOP: begin
        play_d = 1'b0;
        end_d  = 1'b1;
      end
      FUNC_PAUSE: begin
        pause_d = item_i.pause_on;
      end
      FUNC_LOAD: begin
        if (wp_ok) begin
          mem_we_o = 1'b1;
          wp_d     = wp_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!fire_i) begin
      mem_we_o = 1'b0;
      mem_re_o = 1'b0;
    end
    stage_o.is_playing  = play_d;
    stage_o.is_paused   = pause_d;
    stage_o.has_ended   = end_d;
    stage_o.current_lba = lba_d;
  end

  // Reads and writes never share a cycle, and a write lands before any later read
  assign mem_waddr_o = wp_q[ADDR_W-1:0];
  assign mem_raddr_o = rp_q[ADDR_W-1:0];

  // Playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q  <= 1'b0;
      pause_q <= 1'b0;
      end_q   <= 1'b0;
      lba_q   <= '0;
      blk_q   <= '0;
      sl_q    <= '0;
      rp_q    <= '0;
      wp_q    <= '0;
    end else if (fire_i) begin
      play_q  <= play_d;
      pause_q <= pause_d;
      end_q   <= end_d;
      lba_q   <= lba_d;
      blk_q   <= blk_d;
      sl_q    <= sl_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cd_audio_sector_playback.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (cdap_pkg::in_t)
// out       output     out_valid_o / out_stall_i out_data_o (cdap_pkg::out_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (disc loaded)
//
// One item per cycle while in_stall_o is low; a result passes through the cache stage,
// which waits for the registered read port of the sample cache, and then the output register.
// Reset clears all playback state; cache contents stay undefined until loaded.
// Output stall backs up through a two-entry pipe (cache stage, output register)
// and raises in_stall_o only once both hold a result.
`default_nettype none

module cd_audio_sector_playback #(
  parameter int unsigned CACHE_SECTORS = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire cdap_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output cdap_pkg::out_t      out_data_o
);

  import cdap_pkg::*;

  localparam int unsigned CacheWords = CACHE_SECTORS * SAMPLES_PER_SECTOR;
  localparam int unsigned AddrW      = $clog2(CacheWords);

  logic              in_fire;
  logic              s1_adv;
  logic              s1_valid_q;
  stage_t            s1_q;
  stage_t            stage;
  logic              out_valid_q;
  out_t              out_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [31:0]       mem_rdata;

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  cdap_ctrl #(
    .CACHE_SECTORS(CACHE_SECTORS),
    .ADDR_W       (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (in_fire),
    .item_i     (in_data_i),
    .stage_o    (stage),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr)
  );

  cdap_cache #(
    .DEPTH (CacheWords),
    .ADDR_W(AddrW)
  ) u_cache (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(in_data_i.disc_word),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Cache stage: result waits here for read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= stage;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.left_sample   <= s1_q.sample_en ? mem_rdata[31:16] : 16'sd0;
      out_q.right_sample  <= s1_q.sample_en ? mem_rdata[15:0] : 16'sd0;
      out_q.fetch_request <= s1_q.fetch_request;
      out_q.fetch_lba     <= s1_q.fetch_lba;
      out_q.fetch_count   <= s1_q.fetch_count;
      out_q.is_playing    <= s1_q.is_playing;
      out_q.is_paused     <= s1_q.is_paused;
      out_q.has_ended     <= s1_q.has_ended;
      out_q.current_lba   <= s1_q.current_lba;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/cdap_checker.sv
`default_nettype none
`include "cd_audio_sector_playback_macros.svh"

module cdap_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           cfg_we_i,
  input wire logic           cfg_wdata_i,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire cdap_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire cdap_pkg::out_t out_data_o
);

  // A stalled result holds
  `CDAP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "result changed under stall")

  // Fetch address and count only travel with a fetch request
  `CDAP_ASSERT_OUT(a_fetch_zero, out_data_o.fetch_request || (out_data_o.fetch_lba == '0 && out_data_o.fetch_count == '0), "fetch fields without request")

  // Playing and ended are exclusive
  `CDAP_ASSERT_OUT(a_play_end, !(out_data_o.is_playing && out_data_o.has_ended), "playing and ended together")

  // Audio or a fetch only while running unpaused, never both at once
  `CDAP_ASSERT_OUT(a_sample_run, (out_data_o.left_sample != 16'sd0 || out_data_o.right_sample != 16'sd0 || out_data_o.fetch_request) |-> (out_data_o.is_playing && !out_data_o.is_paused && !(out_data_o.fetch_request && (out_data_o.left_sample != 16'sd0 || out_data_o.right_sample != 16'sd0))), "audio or fetch while not running")

endmodule

bind cd_audio_sector_playback cdap_checker u_checker (.*);

`default_nettype wire
